FILE: src/olt_pkg.sv
package olt_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_CLIENT_BITS = 16;
  localparam int DEF_KEY_BITS    = 32;

  localparam int OPCODE_BITS = 2;

  localparam logic [OPCODE_BITS-1:0] OP_TEST_SET = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CHECK    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // Status that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic active;
    logic found;
    logic hit;
    logic free_seen;
  } cell_tok_t;

endpackage

FILE: src/olt_if.sv
interface olt_req_if import olt_pkg::*; #(
  parameter int CLIENT_BITS = DEF_CLIENT_BITS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_BITS-1:0] opcode;
  logic [CLIENT_BITS-1:0] requester;
  logic [KEY_BITS-1:0]    resource_key;

  modport source (output valid, output opcode, output requester, output resource_key,
                  input ready);
  modport sink (input valid, input opcode, input requester, input resource_key,
                output ready);
endinterface

interface olt_rsp_if;
  logic valid;
  logic ready;
  logic answer;
  logic table_full;

  modport source (output valid, output answer, output table_full, input ready);
  modport sink (input valid, input answer, input table_full, output ready);
endinterface

FILE: src/owner_lock_table.sv
// An accepted item is registered, then walks the row of cells one cell per cycle; its result is
// registered and moves to the output register once that register is empty or its result is taken.
// The row of cells serves one item at a time; no new item is accepted until the last one left the row.
// A new item is accepted while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the table and drops any item in progress.
module owner_lock_table import olt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int CLIENT_BITS = DEF_CLIENT_BITS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  olt_req_if.sink   in_req,
  olt_rsp_if.source out_rsp
);

  state_t                 state_r, state_nxt;
  logic                   start_r, start_nxt;
  logic [OPCODE_BITS-1:0] req_op_r;
  logic [CLIENT_BITS-1:0] req_client_r;
  logic [KEY_BITS-1:0]    req_key_r;
  logic                   res_answer_r, res_answer_nxt;
  logic                   res_full_r, res_full_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_answer_r;
  logic                   out_full_r;
  logic                   in_fire;
  logic                   finish;
  logic                   insert;
  logic                   out_load;
  cell_tok_t              tok [TABLE_DEPTH+1];
  cell_tok_t              fin;
  logic [TABLE_DEPTH-1:0] act_vec;

  assign tok[0] = '{active: start_r, found: 1'b0, hit: 1'b0, free_seen: 1'b0};
  assign fin    = tok[TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    olt_cell #(
      .CLIENT_BITS(CLIENT_BITS),
      .KEY_BITS   (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req_op    (req_op_r),
      .req_client(req_client_r),
      .req_key   (req_key_r),
      .insert    (insert),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
    assign act_vec[i] = tok[i+1].active;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (fin.active) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready = 1'b0;
    finish       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE:  in_req.ready = 1'b1;
      ST_WALK:  finish = fin.active;
      ST_DRAIN: out_load = !out_valid_r || out_rsp.ready;
      default: ;
    endcase
  end

  always_comb begin
    in_fire   = in_req.valid && in_req.ready;
    start_nxt = in_fire;
    insert    = finish && (req_op_r == OP_TEST_SET) && !fin.found && fin.free_seen;

    res_answer_nxt = res_answer_r;
    res_full_nxt   = res_full_r;
    if (finish) begin
      res_answer_nxt = 1'b0;
      res_full_nxt   = 1'b0;
      case (req_op_r)
        OP_TEST_SET: begin
          res_answer_nxt = fin.found ? fin.hit : fin.free_seen;
          res_full_nxt   = !fin.found && !fin.free_seen;
        end
        OP_RELEASE: res_answer_nxt = fin.hit;
        OP_CHECK:   res_answer_nxt = fin.hit;
        default:    res_answer_nxt = 1'b0;
      endcase
    end

    out_valid_nxt = out_valid_r && !out_rsp.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r     <= in_req.opcode;
      req_client_r <= in_req.requester;
      req_key_r    <= in_req.resource_key;
    end
    res_answer_r <= res_answer_nxt;
    res_full_r   <= res_full_nxt;
    if (out_load) begin
      out_answer_r <= res_answer_r;
      out_full_r   <= res_full_r;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.answer     = out_answer_r;
  assign out_rsp.table_full = out_full_r;

  // Only one item may be inside the row of cells at any time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(act_vec))
    else $error("more than one item in the cell row");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |-> (act_vec == '0) && !start_r)
    else $error("item accepted while another is in the cell row");

  a_load_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DRAIN)
    else $error("result presented outside the drain step");

  a_answer_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_answer_r && out_full_r))
    else $error("grant and table full reported together");

endmodule

FILE: src/olt_cell.sv
module olt_cell import olt_pkg::*; #(
  parameter int CLIENT_BITS = DEF_CLIENT_BITS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [OPCODE_BITS-1:0] req_op,
  input  logic [CLIENT_BITS-1:0] req_client,
  input  logic [KEY_BITS-1:0]    req_key,
  input  logic                   insert,
  input  cell_tok_t              tok_in,
  output cell_tok_t              tok_out
);

  logic                   valid_r, valid_nxt;
  logic                   claim_r, claim_nxt;
  cell_tok_t              tok_r, tok_nxt;
  logic [CLIENT_BITS-1:0] owner_r;
  logic [KEY_BITS-1:0]    key_r;
  logic                   key_eq;
  logic                   pair_eq;
  logic                   write_en;

  always_comb begin
    key_eq   = valid_r && (key_r == req_key);
    pair_eq  = key_eq && (owner_r == req_client);
    write_en = insert && claim_r;

    tok_nxt           = tok_in;
    tok_nxt.found     = tok_in.found | (tok_in.active & key_eq);
    tok_nxt.hit       = tok_in.hit | (tok_in.active & pair_eq);
    tok_nxt.free_seen = tok_in.free_seen | (tok_in.active & ~valid_r);

    // The first free cell that the item passes remembers that it may take the insert.
    claim_nxt = claim_r;
    if (tok_in.active) begin
      claim_nxt = !valid_r && !tok_in.free_seen;
    end

    valid_nxt = valid_r;
    if (tok_in.active && (req_op == OP_RELEASE) && pair_eq) begin
      valid_nxt = 1'b0;
    end
    if (write_en) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      claim_r <= claim_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      owner_r <= req_client;
      key_r   <= req_key;
    end
  end

  assign tok_out = tok_r;

endmodule
